### rtl/wsce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsce_pkg
// Shared types and constants for the weighted softmax cross-entropy unit.
// ----------------------------------------------------------------------------
package wsce_pkg;

    localparam int MAX_CLASSES = 32;
    localparam int POS_W       = $clog2(MAX_CLASSES);
    localparam int COUNT_W     = 6;
    localparam int ACC_W       = 40;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam int LOG2E_Q16   = 94548;
    localparam int EXP_CORR    = 22512;
    localparam int LOG_CORR    = 22715;
    localparam int LN2_Q16     = 45426;

    typedef struct packed {
        logic signed [15:0] logit;
        logic [15:0]        weight;
        logic               first;
        logic               last;
        logic               hit;
        logic               missing;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP1,
        ST_EXP2,
        ST_EXP3,
        ST_NORM,
        ST_LN1,
        ST_LN2,
        ST_LN3,
        ST_LN4,
        ST_LN5
    } back_state_t;

endpackage

### rtl/wsce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsce_front
// Accepts logits, tracks class position and tags each item for the back end.
// ----------------------------------------------------------------------------
module wsce_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [wsce_pkg::COUNT_W-1:0]  class_count,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_logit,
    input  logic [4:0]                    s_target_class,
    input  logic [15:0]                   s_loss_weight,
    input  logic                          q_full,
    output logic                          q_push,
    output wsce_pkg::entry_t              q_data
);

    logic [wsce_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [4:0]                   tgt_reg, tgt_next;
    logic [wsce_pkg::COUNT_W-1:0] count_eff;
    logic [wsce_pkg::COUNT_W:0]   pos_plus;
    logic                         first;
    logic                         last;

    always_comb begin
        if (class_count == '0) begin
            count_eff = wsce_pkg::COUNT_W'(1);
        end else if (class_count > wsce_pkg::COUNT_W'(wsce_pkg::MAX_CLASSES)) begin
            count_eff = wsce_pkg::COUNT_W'(wsce_pkg::MAX_CLASSES);
        end else begin
            count_eff = class_count;
        end
    end

    assign s_ready  = !q_full;
    assign q_push   = s_valid && s_ready;
    assign first    = (pos_reg == '0);
    assign pos_plus = (wsce_pkg::COUNT_W+1)'(pos_reg) + 1'b1;
    assign last     = (pos_plus >= {1'b0, count_eff});
    assign tgt_next = first ? s_target_class : tgt_reg;

    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            pos_next = last ? '0 : pos_plus[wsce_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        q_data.logit   = s_logit;
        q_data.weight  = s_loss_weight;
        q_data.first   = first;
        q_data.last    = last;
        q_data.hit     = ((wsce_pkg::COUNT_W)'(pos_reg) == (wsce_pkg::COUNT_W)'(tgt_next));
        q_data.missing = ((wsce_pkg::COUNT_W)'(tgt_next) >= count_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            tgt_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            if (q_push) begin
                tgt_reg <= tgt_next;
            end
        end
    end

endmodule

### rtl/wsce_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsce_fifo
// Short item queue between the front and the back end.
// ----------------------------------------------------------------------------
module wsce_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  wsce_pkg::entry_t push_data,
    input  logic             pop,
    output wsce_pkg::entry_t pop_data,
    output logic             full,
    output logic             empty
);

    wsce_pkg::entry_t             mem [wsce_pkg::FIFO_DEPTH];
    logic [wsce_pkg::FIFO_AW-1:0] wr_reg, rd_reg;
    logic [wsce_pkg::FIFO_AW:0]   cnt_reg, cnt_next;
    logic                         do_push, do_pop;

    assign full     = (cnt_reg == (wsce_pkg::FIFO_AW+1)'(wsce_pkg::FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (wsce_pkg::FIFO_AW+1)'(wsce_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_reg - rd_reg) == cnt_reg[wsce_pkg::FIFO_AW-1:0])
        else $error("queue pointers disagree with count");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("pop did not lower count");

endmodule

### rtl/wsce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsce_back
// Exp-accumulate per item, then log and weighting at the end of a position.
// ----------------------------------------------------------------------------
module wsce_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  wsce_pkg::entry_t        q_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [31:0]      m_loss,
    output logic                    m_target_missing
);

    wsce_pkg::back_state_t       state_reg, state_next;
    wsce_pkg::entry_t            ent_reg;
    logic [4:0]                  ip_reg;
    logic [15:0]                 f_reg;
    logic [16:0]                 t_reg;
    logic [wsce_pkg::ACC_W-1:0]  acc_reg;
    logic signed [15:0]          tlog_reg;
    logic [15:0]                 weight_reg;
    logic [wsce_pkg::ACC_W-1:0]  norm_reg;
    logic [5:0]                  e_reg;
    logic signed [25:0]          lbig_reg;
    logic signed [27:0]          ln_reg;
    logic signed [28:0]          d_reg;
    logic                        m_valid_reg;
    logic signed [31:0]          m_loss_reg;
    logic                        m_missing_reg;

    // exp datapath
    logic signed [33:0]          v_exp;
    logic [15:0]                 frac;
    logic [16:0]                 fc;
    logic [33:0]                 fprod;
    logic [31:0]                 qprod;
    logic [16:0]                 mant;
    logic [wsce_pkg::ACC_W-1:0]  mant_w;
    logic [wsce_pkg::ACC_W-1:0]  term;
    logic [wsce_pkg::ACC_W-1:0]  acc_base;
    // log datapath
    logic [31:0]                 lprod;
    logic [17:0]                 lfrac;
    logic signed [6:0]           esub;
    logic signed [43:0]          lnprod;
    logic signed [28:0]          dval;
    logic signed [45:0]          wprod;
    logic signed [29:0]          wq;
    logic                        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign frac     = (state_reg == wsce_pkg::ST_EXP2) ? f_reg : norm_reg[38:23];
    assign fc       = 17'd65536 - {1'b0, frac};
    assign fprod    = 34'({1'b0, frac}) * 34'(fc);

    assign v_exp    = 34'(ent_reg.logit) * 34'(wsce_pkg::LOG2E_Q16) + (34'sd1 <<< 32);
    assign qprod    = 32'(t_reg) * 32'(wsce_pkg::EXP_CORR);
    assign mant     = 17'd65536 + {1'b0, f_reg} - {1'b0, qprod[31:16]};
    assign mant_w   = wsce_pkg::ACC_W'(mant);
    assign term     = (ip_reg >= 5'd16) ? (mant_w << (ip_reg - 5'd16))
                                        : (mant_w >> (5'd16 - ip_reg));
    assign acc_base = ent_reg.first ? '0 : acc_reg;

    assign lprod    = 32'(t_reg) * 32'(wsce_pkg::LOG_CORR);
    assign lfrac    = 18'(norm_reg[38:23]) + 18'(lprod[31:16]);
    assign esub     = $signed({1'b0, e_reg}) - 7'sd16;
    assign lnprod   = 44'(lbig_reg) * 44'(wsce_pkg::LN2_Q16);
    assign dval     = $signed({{9{tlog_reg[15]}}, tlog_reg, 4'b0000}) - 29'(ln_reg);
    assign wprod    = $signed({30'd0, weight_reg}) * 46'(d_reg);
    assign wq       = 30'(wprod >>> 16);

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            wsce_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = wsce_pkg::ST_EXP1;
                end
            end
            wsce_pkg::ST_EXP1: state_next = wsce_pkg::ST_EXP2;
            wsce_pkg::ST_EXP2: state_next = wsce_pkg::ST_EXP3;
            wsce_pkg::ST_EXP3: begin
                if (!ent_reg.last) begin
                    state_next = wsce_pkg::ST_IDLE;
                end else if (ent_reg.missing || (acc_base + term) == '0) begin
                    state_next = wsce_pkg::ST_LN5;
                end else begin
                    state_next = wsce_pkg::ST_NORM;
                end
            end
            wsce_pkg::ST_NORM: begin
                if (norm_reg[39]) begin
                    state_next = wsce_pkg::ST_LN1;
                end
            end
            wsce_pkg::ST_LN1: state_next = wsce_pkg::ST_LN2;
            wsce_pkg::ST_LN2: state_next = wsce_pkg::ST_LN3;
            wsce_pkg::ST_LN3: state_next = wsce_pkg::ST_LN4;
            wsce_pkg::ST_LN4: state_next = wsce_pkg::ST_LN5;
            wsce_pkg::ST_LN5: begin
                if (out_free) begin
                    state_next = wsce_pkg::ST_IDLE;
                end
            end
            default: state_next = wsce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wsce_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            tlog_reg    <= '0;
            weight_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == wsce_pkg::ST_LN5 && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == wsce_pkg::ST_EXP3) begin
                acc_reg <= acc_base + term;
                if (ent_reg.first) begin
                    weight_reg <= ent_reg.weight;
                end
                if (ent_reg.hit) begin
                    tlog_reg <= ent_reg.logit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_data;
        end
        case (state_reg)
            wsce_pkg::ST_EXP1: begin
                ip_reg <= v_exp[32:28];
                f_reg  <= v_exp[27:12];
            end
            wsce_pkg::ST_EXP2: t_reg <= fprod[32:16];
            wsce_pkg::ST_EXP3: begin
                norm_reg <= acc_base + term;
                e_reg    <= 6'd39;
            end
            wsce_pkg::ST_NORM: begin
                // shift by a byte while possible, then bit by bit
                if (norm_reg[39:32] == 8'd0 && e_reg >= 6'd8) begin
                    norm_reg <= norm_reg << 8;
                    e_reg    <= e_reg - 6'd8;
                end else if (!norm_reg[39]) begin
                    norm_reg <= norm_reg << 1;
                    e_reg    <= e_reg - 6'd1;
                end
            end
            wsce_pkg::ST_LN1: t_reg <= fprod[32:16];
            wsce_pkg::ST_LN2: lbig_reg <= {{3{esub[6]}}, esub, 16'd0} + 26'(lfrac);
            wsce_pkg::ST_LN3: ln_reg <= 28'(lnprod >>> 16);
            wsce_pkg::ST_LN4: d_reg <= (dval > 29'sd0) ? 29'sd0 : dval;
            wsce_pkg::ST_LN5: begin
                if (out_free) begin
                    m_missing_reg <= ent_reg.missing;
                    if (ent_reg.missing) begin
                        m_loss_reg <= '0;
                    end else if (acc_reg == '0) begin
                        m_loss_reg <= 32'sh8000_0000;
                    end else if (wq > 30'sd0) begin
                        m_loss_reg <= '0;
                    end else begin
                        m_loss_reg <= 32'(wq);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_loss           = m_loss_reg;
    assign m_target_missing = m_missing_reg;

    a_norm_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wsce_pkg::ST_LN1) |-> norm_reg[39])
        else $error("log input not normalized");
    a_loss_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_loss_reg[31] || m_loss_reg == '0))
        else $error("positive loss emitted");
    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_missing_reg) |-> (m_loss_reg == '0))
        else $error("missing target with nonzero loss");
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == wsce_pkg::ST_IDLE))
        else $error("queue popped while busy");

endmodule

### rtl/weighted_softmax_cross_entropy_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_softmax_cross_entropy_unit
// Streams class logits and emits one weighted log-softmax loss per position.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one Q4.12 logit per item, in class order. target_class and
//   loss_weight are taken from the first item of each position.
//   m_* carries one Q16.16 loss per position after class_count items, with
//   target_missing set (loss zero) when the target is not below the count.
//   cfg_* writes class_count (0 acts as 1, above 32 clamps to 32); write it
//   only while no position result is pending.
// Flow:
//   A four-entry queue decouples the input from the back end. The back end
//   handles one logit at a time and pops no new one until it is done: pop,
//   exp argument, exp fraction multiply, accumulate. The last item of a
//   position adds a log pass (normalize by byte and bit shifts, then the log
//   multiplies and weighting) unless the target is missing or the sum is zero.
// Reset clears position, queue and output valid; class_count returns to 32.
// While m_ready is low the result is held, the back end waits before writing
// the next result, and the queue fills until s_ready drops.
// ----------------------------------------------------------------------------
module weighted_softmax_cross_entropy_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsce_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_logit,
    input  logic [4:0]                    s_target_class,
    input  logic [15:0]                   s_loss_weight,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_loss,
    output logic                          m_target_missing
);

    logic [wsce_pkg::COUNT_W-1:0] count_reg;
    logic                         q_push, q_pop, q_full, q_empty;
    wsce_pkg::entry_t             push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= wsce_pkg::COUNT_W'(wsce_pkg::MAX_CLASSES);
        end else if (cfg_valid && cfg_ready) begin
            count_reg <= cfg_data;
        end
    end

    wsce_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .class_count    (count_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_logit        (s_logit),
        .s_target_class (s_target_class),
        .s_loss_weight  (s_loss_weight),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (push_data)
    );

    wsce_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    wsce_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .q_data           (pop_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_loss           (m_loss),
        .m_target_missing (m_target_missing)
    );

endmodule
